FILE: rtl/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and codes for the first-fit byte allocator: request and
// result payloads, status codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int KIND_W   = 1;
  localparam int LEN_W    = 9;
  localparam int ADDR_FW  = 8;
  localparam int STATUS_W = 3;
  localparam int FREE_W   = 9;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO_LEN   = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [LEN_W-1:0]   length;
    logic [ADDR_FW-1:0] start_address;
  } ffba_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_FW-1:0]  granted_address;
    logic [FREE_W-1:0]   free_bytes;
  } ffba_out_t;

  // controller -> datapath
  typedef struct packed {
    logic                take;
    logic                clear;
    logic                slot_step;
    logic                scan_start;
    logic                scan_step;
    logic                mark_step;
    logic                look_start;
    logic                look_step;
    logic                release_step;
    logic                result_load;
    logic [STATUS_W-1:0] status;
  } ffba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic              clear_last;
    logic [KIND_W-1:0] kind;
    logic              len_zero;
    logic              len_over;
    logic              slot_free;
    logic              slot_last;
    logic              scan_found;
    logic              scan_end;
    logic              look_hit;
    logic              look_end;
    logic              fill_last;
    logic              out_busy;
  } ffba_sts_t;

endpackage

FILE: rtl/first_fit_byte_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_byte_allocator
// First-fit allocator over a pool of POOL_BYTES byte cells with a table of
// MAX_BLOCKS live runs. Requests come in on in_*, one result per request
// leaves on out_*. Both channels transfer when valid is high and stall low.
//
// Allocate (kind 0) searches the table for the lowest free entry (one entry
// a cycle), then scans the occupancy memory from cell 0, one cell a cycle,
// for the first run of the requested length, and marks that run one cell a
// cycle. Free (kind 1) looks up the table one entry a cycle, then clears the
// run one cell a cycle. The single-port occupancy memory sets the
// one-cell-per-cycle pace. One request is in work at a time.
//
// After reset the occupancy memory is cleared while in_stall is held
// high. A finished result sits in the output register; a new
// request is taken while it waits, and its own result is held back until
// the receiver takes the earlier one.
// ----------------------------------------------------------------------------
module first_fit_byte_allocator
  import ffba_pkg::*;
#(
  parameter int POOL_BYTES = 256,
  parameter int MAX_BLOCKS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ffba_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ffba_out_t out_data
);

  ffba_cmd_t cmd;
  ffba_sts_t sts;

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffba_dp #(
    .POOL_BYTES (POOL_BYTES),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input transfer not followed by stall");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result_load |-> !(out_valid && out_stall))
    else $error("result loaded over a pending transfer");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> (out_data.granted_address == '0))
    else $error("granted address set on a failed request");

  a_no_mark_release: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark_step |-> !cmd.release_step && !cmd.scan_step && !cmd.clear)
    else $error("conflicting occupancy memory commands");
`endif

endmodule

FILE: rtl/ffba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer for the allocator: clearing pass, table slot search, first-fit
// scan, run marking, table lookup, run release and result hand-off.
// ----------------------------------------------------------------------------
module ffba_ctrl
  import ffba_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ffba_sts_t sts,
  output ffba_cmd_t cmd
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DECODE  = 4'd2;
  localparam logic [3:0] S_SLOT    = 4'd3;
  localparam logic [3:0] S_SCAN    = 4'd4;
  localparam logic [3:0] S_MARK    = 4'd5;
  localparam logic [3:0] S_LOOK    = 4'd6;
  localparam logic [3:0] S_RELEASE = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    status_nxt = status_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.kind == KIND_FREE) begin
          cmd.look_start = 1'b1;
          state_nxt      = S_LOOK;
        end else if (sts.len_zero) begin
          status_nxt = ST_ZERO_LEN;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_SLOT;
        end
      end
      S_SLOT: begin
        if (sts.slot_free) begin
          if (sts.len_over) begin
            status_nxt = ST_NO_SPACE;
            state_nxt  = S_DONE;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end else if (sts.slot_last) begin
          status_nxt = ST_TABLE_FULL;
          state_nxt  = S_DONE;
        end else begin
          cmd.slot_step = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_found) begin
          state_nxt = S_MARK;
        end else if (sts.scan_end) begin
          status_nxt = ST_NO_SPACE;
          state_nxt  = S_DONE;
        end
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        if (sts.fill_last) begin
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
        end
      end
      S_LOOK: begin
        cmd.look_step = 1'b1;
        if (sts.look_hit) begin
          state_nxt = S_RELEASE;
        end else if (sts.look_end) begin
          status_nxt = ST_UNKNOWN;
          state_nxt  = S_DONE;
        end
      end
      S_RELEASE: begin
        cmd.release_step = 1'b1;
        if (sts.fill_last) begin
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        cmd.status = status_r;
        if (!sts.out_busy) begin
          cmd.result_load = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

endmodule

FILE: rtl/ffba_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_dp
// Allocator datapath: occupancy memory, block table memory with valid bits,
// scan and fill counters, free count and the result register.
// ----------------------------------------------------------------------------
module ffba_dp
  import ffba_pkg::*;
#(
  parameter int POOL_BYTES = 256,
  parameter int MAX_BLOCKS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ffba_in_t  in_data,
  input  ffba_cmd_t cmd,
  output ffba_sts_t sts,
  output logic      out_valid,
  input  logic      out_stall,
  output ffba_out_t out_data
);

  localparam int ADDR_W = $clog2(POOL_BYTES);
  localparam int CNT_W  = $clog2(POOL_BYTES + 1);
  localparam int SLOT_W = $clog2(MAX_BLOCKS);
  localparam int LW     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int CMP_W  = (ADDR_W > ADDR_FW) ? ADDR_W : ADDR_FW;
  localparam int TBL_W  = ADDR_W + CNT_W;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(POOL_BYTES - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_BLOCKS - 1);

  logic [KIND_W-1:0]     kind_r, kind_nxt;
  logic [LW-1:0]         len_r, len_nxt;
  logic [ADDR_FW-1:0]    sa_r, sa_nxt;
  logic [ADDR_W-1:0]     cell_r, cell_nxt;
  logic [ADDR_W-1:0]     chk_cell_r, chk_cell_nxt;
  logic [ADDR_W-1:0]     pos_r, pos_nxt;
  logic [LW-1:0]         run_r, run_nxt;
  logic                  chk_v_r, chk_v_nxt;
  logic                  issue_done_r, issue_done_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [SLOT_W-1:0]     chk_slot_r, chk_slot_nxt;
  logic [MAX_BLOCKS-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]      free_r, free_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ffba_out_t             out_data_r, out_data_nxt;

  logic                  occ_mem [POOL_BYTES];
  logic                  occ_rd_r;
  logic [TBL_W-1:0]      tbl_mem [MAX_BLOCKS];
  logic [TBL_W-1:0]      tbl_rd_r;

  logic [ADDR_W-1:0]     tbl_start;
  logic [CNT_W-1:0]      tbl_len;
  logic [LW-1:0]         run_inc;
  logic [LW-1:0]         pos_calc;
  logic                  scan_found;
  logic                  scan_end;
  logic                  look_hit;
  logic                  look_end;
  logic                  fill_last;
  logic                  occ_we;
  logic [ADDR_FW-1:0]    granted;

  assign tbl_start  = tbl_rd_r[TBL_W-1 -: ADDR_W];
  assign tbl_len    = tbl_rd_r[CNT_W-1:0];
  assign run_inc    = run_r + LW'(1);
  // start of the run that ends at the cell just checked
  assign pos_calc   = LW'(chk_cell_r) + LW'(1) - len_r;
  assign scan_found = chk_v_r && !occ_rd_r && (run_inc == len_r);
  assign scan_end   = chk_v_r && (chk_cell_r == LAST_CELL) && !scan_found;
  assign look_hit   = chk_v_r && valid_r[chk_slot_r] &&
                      (CMP_W'(sa_r) == CMP_W'(tbl_start));
  assign look_end   = chk_v_r && (chk_slot_r == LAST_SLOT) && !look_hit;
  assign fill_last  = (run_inc == len_r);
  assign occ_we     = cmd.clear || cmd.mark_step || cmd.release_step;
  assign granted    = ((cmd.status == ST_OK) && (kind_r == KIND_ALLOC)) ?
                      ADDR_FW'(pos_r) : '0;

  always_comb begin
    kind_nxt       = kind_r;
    len_nxt        = len_r;
    sa_nxt         = sa_r;
    cell_nxt       = cell_r;
    chk_cell_nxt   = chk_cell_r;
    pos_nxt        = pos_r;
    run_nxt        = run_r;
    chk_v_nxt      = chk_v_r;
    issue_done_nxt = issue_done_r;
    slot_nxt       = slot_r;
    chk_slot_nxt   = chk_slot_r;
    valid_nxt      = valid_r;
    free_nxt       = free_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (cmd.take) begin
      kind_nxt = in_data.kind;
      len_nxt  = LW'(in_data.length);
      sa_nxt   = in_data.start_address;
      slot_nxt = '0;
    end

    if (cmd.clear) begin
      cell_nxt = (cell_r == LAST_CELL) ? '0 : cell_r + ADDR_W'(1);
    end

    if (cmd.slot_step) begin
      slot_nxt = slot_r + SLOT_W'(1);
    end

    if (cmd.scan_start) begin
      cell_nxt       = '0;
      run_nxt        = '0;
      chk_v_nxt      = 1'b0;
      issue_done_nxt = 1'b0;
    end

    if (cmd.look_start) begin
      slot_nxt       = '0;
      chk_v_nxt      = 1'b0;
      issue_done_nxt = 1'b0;
    end

    // read issued at cell_r, checked in the next cycle at chk_cell_r
    if (cmd.scan_step) begin
      chk_v_nxt    = !issue_done_r;
      chk_cell_nxt = cell_r;
      if (!issue_done_r) begin
        if (cell_r == LAST_CELL) begin
          issue_done_nxt = 1'b1;
        end else begin
          cell_nxt = cell_r + ADDR_W'(1);
        end
      end
      if (chk_v_r) begin
        run_nxt = occ_rd_r ? '0 : run_inc;
      end
      if (scan_found) begin
        pos_nxt  = pos_calc[ADDR_W-1:0];
        cell_nxt = pos_calc[ADDR_W-1:0];
        run_nxt  = '0;
      end
    end

    if (cmd.look_step) begin
      chk_v_nxt    = !issue_done_r;
      chk_slot_nxt = slot_r;
      if (!issue_done_r) begin
        if (slot_r == LAST_SLOT) begin
          issue_done_nxt = 1'b1;
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
      end
      if (look_hit) begin
        slot_nxt = chk_slot_r;
        cell_nxt = tbl_start;
        len_nxt  = LW'(tbl_len);
        run_nxt  = '0;
      end
    end

    if (cmd.mark_step || cmd.release_step) begin
      cell_nxt = cell_r + ADDR_W'(1);
      run_nxt  = run_inc;
      if (fill_last) begin
        if (cmd.mark_step) begin
          valid_nxt[slot_r] = 1'b1;
          free_nxt          = free_r - CNT_W'(len_r);
        end else begin
          valid_nxt[slot_r] = 1'b0;
          free_nxt          = free_r + CNT_W'(len_r);
        end
      end
    end

    if (cmd.result_load) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.status          = cmd.status;
      out_data_nxt.granted_address = granted;
      out_data_nxt.free_bytes      = FREE_W'(free_r);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r       <= '0;
      chk_v_r      <= 1'b0;
      issue_done_r <= 1'b0;
      valid_r      <= '0;
      free_r       <= CNT_W'(POOL_BYTES);
      out_valid_r  <= 1'b0;
    end else begin
      cell_r       <= cell_nxt;
      chk_v_r      <= chk_v_nxt;
      issue_done_r <= issue_done_nxt;
      valid_r      <= valid_nxt;
      free_r       <= free_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    len_r      <= len_nxt;
    sa_r       <= sa_nxt;
    chk_cell_r <= chk_cell_nxt;
    pos_r      <= pos_nxt;
    run_r      <= run_nxt;
    slot_r     <= slot_nxt;
    chk_slot_r <= chk_slot_nxt;
    out_data_r <= out_data_nxt;
  end

  // occupancy map: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[cell_r] <= cmd.mark_step;
    end
    occ_rd_r <= occ_mem[cell_r];
  end

  // block table: start and length per entry
  always_ff @(posedge clk) begin
    if (cmd.mark_step && fill_last) begin
      tbl_mem[slot_r] <= {pos_r, CNT_W'(len_r)};
    end
    tbl_rd_r <= tbl_mem[slot_r];
  end

  always_comb begin
    sts            = '0;
    sts.clear_last = (cell_r == LAST_CELL);
    sts.kind       = kind_r;
    sts.len_zero   = (len_r == '0);
    sts.len_over   = (len_r > LW'(POOL_BYTES));
    sts.slot_free  = !valid_r[slot_r];
    sts.slot_last  = (slot_r == LAST_SLOT);
    sts.scan_found = scan_found;
    sts.scan_end   = scan_end;
    sts.look_hit   = look_hit;
    sts.look_end   = look_end;
    sts.fill_last  = fill_last;
    sts.out_busy   = out_valid_r && out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: bench/ffba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_checker
// Watches the request and result channels of the first-fit byte allocator.
// Keeps its own copy of the occupancy map, run table and free count, works
// out the result of every accepted request and compares each result
// transfer field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ffba_checker
  import ffba_pkg::*;
#(
  parameter int POOL_SIZE = 256,
  parameter int TABLE_SIZE = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  ffba_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  ffba_out_t out_data,
  output int        fail_count,
  output int        pending
);

  logic [POOL_SIZE-1:0] cell_used;
  logic                 run_live  [TABLE_SIZE];
  logic [ADDR_FW-1:0]   run_start [TABLE_SIZE];
  logic [LEN_W-1:0]     run_len   [TABLE_SIZE];
  logic [FREE_W-1:0]    bytes_free;

  ffba_out_t due_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic apply_request(input ffba_in_t req, output ffba_out_t res);
    int slot;
    int pos;
    int run;
    int n;
    int i;
    res        = '0;
    res.status = ST_OK;
    if (req.kind == KIND_ALLOC) begin
      n = req.length;
      if (n == 0) begin
        res.status = ST_ZERO_LEN;
      end else begin
        slot = -1;
        for (i = 0; i < TABLE_SIZE; i++)
          if (!run_live[i] && slot < 0) slot = i;
        // table occupancy is checked before any scan
        if (slot < 0) begin
          res.status = ST_TABLE_FULL;
        end else begin
          pos = -1;
          run = 0;
          if (n <= POOL_SIZE) begin
            for (i = 0; i < POOL_SIZE && pos < 0; i++) begin
              if (cell_used[i]) begin
                run = 0;
              end else begin
                run++;
                if (run == n) pos = i + 1 - n;
              end
            end
          end
          if (pos < 0) begin
            res.status = ST_NO_SPACE;
          end else begin
            for (i = pos; i < pos + n; i++) cell_used[i] = 1'b1;
            run_live[slot]      = 1'b1;
            run_start[slot]     = pos[ADDR_FW-1:0];
            run_len[slot]       = n[LEN_W-1:0];
            bytes_free          = bytes_free - n[FREE_W-1:0];
            res.granted_address = pos[ADDR_FW-1:0];
          end
        end
      end
    end else begin
      slot = -1;
      for (i = 0; i < TABLE_SIZE; i++)
        if (run_live[i] && run_start[i] == req.start_address && slot < 0) slot = i;
      if (slot < 0) begin
        res.status = ST_UNKNOWN;
      end else begin
        for (i = 0; i < run_len[slot]; i++)
          if (run_start[slot] + i < POOL_SIZE) cell_used[run_start[slot] + i] = 1'b0;
        bytes_free     = bytes_free + run_len[slot];
        run_live[slot] = 1'b0;
      end
    end
    res.free_bytes = bytes_free;
  endtask

  always @(posedge clk) begin
    ffba_out_t predicted;
    ffba_out_t oldest;
    if (!rst_n) begin
      cell_used  = '0;
      bytes_free = POOL_SIZE[FREE_W-1:0];
      for (int i = 0; i < TABLE_SIZE; i++) begin
        run_live[i]  = 1'b0;
        run_start[i] = '0;
        run_len[i]   = '0;
      end
      due_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        apply_request(in_data, predicted);
        due_results.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result transfer with nothing outstanding, actual %h",
                   $time, out_data);
          fail_count = fail_count + 1;
        end else begin
          oldest = due_results.pop_front();
          if (out_data.status !== oldest.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, oldest.status, out_data.status);
            fail_count = fail_count + 1;
          end
          if (out_data.granted_address !== oldest.granted_address) begin
            $display("%0t: granted_address expected %0d actual %0d",
                     $time, oldest.granted_address, out_data.granted_address);
            fail_count = fail_count + 1;
          end
          if (out_data.free_bytes !== oldest.free_bytes) begin
            $display("%0t: free_bytes expected %0d actual %0d",
                     $time, oldest.free_bytes, out_data.free_bytes);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    pending <= due_results.size();
  end

endmodule

FILE: bench/first_fit_byte_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_byte_allocator_test
// Drives the allocator with a directed set of corner requests, then with a
// long random mix of allocations and frees, most of them of live runs, with
// random idle bursts on both channels. Checking is done by ffba_checker.
// ----------------------------------------------------------------------------
module first_fit_byte_allocator_test;
  import ffba_pkg::*;

  localparam int RANDOM_ITEMS = 1500;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  ffba_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ffba_out_t out_data;

  int fail_count;
  int pending;
  bit idle_on = 1'b1;

  logic [KIND_W-1:0]  kinds_in_flight[$];
  logic [ADDR_FW-1:0] live_starts[$];

  first_fit_byte_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ffba_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // collect granted starts so that frees can target live runs
  always @(posedge clk) begin
    logic [KIND_W-1:0] k;
    if (rst_n) begin
      if (in_valid && !in_stall) kinds_in_flight.push_back(in_data.kind);
      if (out_valid && !out_stall && kinds_in_flight.size() != 0) begin
        k = kinds_in_flight.pop_front();
        if (k == KIND_ALLOC && out_data.status == ST_OK)
          live_starts.push_back(out_data.granted_address);
      end
    end
  end

  // receiver stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic issue(input logic [KIND_W-1:0] kind, input int len, input int addr);
    ffba_in_t req;
    req.kind          = kind;
    req.length        = len[LEN_W-1:0];
    req.start_address = addr[ADDR_FW-1:0];
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 6) return $urandom_range(257, 511);
    if (r < 70) return $urandom_range(1, 16);
    if (r < 92) return $urandom_range(17, 64);
    return $urandom_range(65, 256);
  endfunction

  initial begin
    int idx;
    int addr;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // zero length, oversize, whole pool, full pool, double free
    issue(KIND_ALLOC, 0, 8'hFF);
    issue(KIND_ALLOC, 511, 0);
    issue(KIND_ALLOC, 257, 0);
    issue(KIND_ALLOC, 256, 8'hAA);
    issue(KIND_ALLOC, 1, 0);
    issue(KIND_FREE, 9'h1FF, 8'h00);
    issue(KIND_FREE, 0, 8'h00);
    issue(KIND_FREE, 0, 8'hFF);
    // sixteen runs fill both the table and the pool
    for (int k = 0; k < 16; k++) issue(KIND_ALLOC, 16, k);
    issue(KIND_ALLOC, 1, 0);
    issue(KIND_ALLOC, 0, 0);
    issue(KIND_FREE, 0, 8'h55);   // inside a run
    issue(KIND_FREE, 0, 8'hF0);
    issue(KIND_FREE, 0, 8'h10);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // quiet stretch in the middle and no idling at the tail
      idle_on = !((n >= 600 && n < 800) || n >= 1300);
      if ($urandom_range(0, 99) < 55) begin
        issue(KIND_ALLOC, pick_length(), $urandom_range(0, 255));
      end else begin
        if (live_starts.size() != 0 && $urandom_range(0, 3) != 0) begin
          idx  = $urandom_range(0, live_starts.size() - 1);
          addr = live_starts[idx];
          live_starts.delete(idx);
        end else begin
          addr = $urandom_range(0, 255);
        end
        issue(KIND_FREE, $urandom_range(0, 511), addr);
      end
    end
    in_valid <= 1'b0;

    // let the checker count the last transfer before polling
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/ffba_pkg.sv
rtl/ffba_ctrl.sv
rtl/ffba_dp.sv
rtl/first_fit_byte_allocator.sv
bench/ffba_checker.sv
bench/first_fit_byte_allocator_test.sv
